// ===== hdl/iparb_pkg.sv =====
// Shared types, field widths, command codes and defaults of the interrupt priority arbiter.
`default_nettype none

package iparb_pkg;

  localparam int CMD_W  = 3;
  localparam int SLOT_W = 4;
  localparam int PRIO_W = 3;
  localparam int MINP_W = 4;

  localparam int NUM_SLOTS_DEF    = 16;
  localparam int MAX_PRIORITY_DEF = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_DEREGISTER = 3'd1,
    CMD_RAISE      = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  localparam logic STATUS_APPLIED = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // Best candidate seen so far during a rescan.
  typedef struct packed {
    logic              vld;
    logic [PRIO_W-1:0] prio;
  } win_t;

  // Verdict of the shared priority comparator.
  typedef struct packed {
    logic take;
    logic at_max;
  } cmp_t;

endpackage

`default_nettype wire

// ===== hdl/iparb_cmp.sv =====
// Shared priority comparator used once per scanned slot.
`default_nettype none

module iparb_cmp #(
  parameter int MAX_PRIORITY = iparb_pkg::MAX_PRIORITY_DEF
) (
  input  logic                          elig_i,
  input  logic [iparb_pkg::PRIO_W-1:0]  cand_prio_i,
  input  iparb_pkg::win_t               best_i,
  output iparb_pkg::cmp_t               res_o
);
  import iparb_pkg::*;

  // A candidate replaces the best one only when strictly higher, so the
  // earliest registered slot keeps a tie.
  assign res_o.take   = elig_i && (!best_i.vld || (best_i.prio < cand_prio_i));
  assign res_o.at_max = (32'(cand_prio_i) == MAX_PRIORITY);

endmodule

`default_nettype wire

// ===== hdl/interrupt_priority_arbiter_core.sv =====
// Top level of the interrupt priority arbiter: command sequencer, slot tables and rescan.
`default_nettype none

// Channel   Direction  Handshake              Word
// -------   ---------  ---------------------  ------------------------------------------
// in        sink       in_valid_i/in_stall_o  command, slot, priority_req, can_interrupt,
//                                             min_priority
// out       source     out_valid_o/out_stall_i winner_valid, winner_slot, winner_priority,
//                                             query_hit, status
//
// Every input word produces exactly one output word. A word is captured, then applied,
// then rescanned (one order entry per cycle through the order memory's single read
// port, then the priority read and the compare), and the result is then handed off.
// A deregister first compacts the order list. A rescan may end early once a pending
// slot of the maximum priority is found. Reset clears all flags, the order count and
// the output register; the priority and order memories need no clearing. The input
// is stalled while a word is in work; a word may be taken while the previous result
// still waits downstream.

module interrupt_priority_arbiter_core #(
  parameter int NUM_SLOTS    = iparb_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PRIORITY = iparb_pkg::MAX_PRIORITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [iparb_pkg::CMD_W-1:0]   command_i,
  input  logic [iparb_pkg::SLOT_W-1:0]  slot_i,
  input  logic [iparb_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic                          can_interrupt_i,
  input  logic [iparb_pkg::MINP_W-1:0]  min_priority_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          winner_valid_o,
  output logic [iparb_pkg::SLOT_W-1:0]  winner_slot_o,
  output logic [iparb_pkg::PRIO_W-1:0]  winner_priority_o,
  output logic                          query_hit_o,
  output logic                          status_o
);
  import iparb_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_COMPACT,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  // Captured command word.
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              cap_q, cap_d;
  logic [MINP_W-1:0] minp_q, minp_d;
  logic              status_q, status_d;

  // Per-slot flags live in flip-flops so reset clears them at once.
  logic [NUM_SLOTS-1:0] can_q, can_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic [NUM_SLOTS-1:0] reg_q, reg_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;   // read pointer into the order list
  logic [CNT_W-1:0] jdx_q, jdx_d;   // write pointer during compaction

  // Scan pipeline: order read, then priority read, then compare.
  logic             v1_q, v1_d;
  logic             v2_q, v2_d;
  logic             elig_q, elig_d;
  logic [IDX_W-1:0] s2_q, s2_d;
  logic             stop_q, stop_d;

  win_t             best_q, best_d;
  logic [IDX_W-1:0] best_slot_q, best_slot_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              wv_q, wv_d;
  logic [SLOT_W-1:0] ws_q, ws_d;
  logic [PRIO_W-1:0] wp_q, wp_d;
  logic              hit_q, hit_d;
  logic              st_q, st_d;

  // Memories.
  logic [IDX_W-1:0]  order_mem [NUM_SLOTS];
  logic [PRIO_W-1:0] prio_mem  [NUM_SLOTS];
  logic [IDX_W-1:0]  order_rd_q;
  logic [PRIO_W-1:0] prio_rd_q;

  logic              order_we;
  logic [IDX_W-1:0]  order_waddr;
  logic [IDX_W-1:0]  order_wdata;
  logic              prio_we;

  logic              in_accept;
  logic              in_range;
  logic [IDX_W-1:0]  slot_idx;
  logic              rd_in_range;
  cmp_t              cmp_res;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = (32'(slot_q) < NUM_SLOTS);
  assign slot_idx    = IDX_W'(slot_q);
  assign rd_in_range = (32'(order_rd_q) < NUM_SLOTS);

  iparb_cmp #(
    .MAX_PRIORITY (MAX_PRIORITY)
  ) u_cmp (
    .elig_i      (elig_q),
    .cand_prio_i (prio_rd_q),
    .best_i      (best_q),
    .res_o       (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    prio_d      = prio_q;
    cap_d       = cap_q;
    minp_d      = minp_q;
    status_d    = status_q;
    can_d       = can_q;
    pend_d      = pend_q;
    reg_d       = reg_q;
    count_d     = count_q;
    idx_d       = idx_q;
    jdx_d       = jdx_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    elig_d      = 1'b0;
    s2_d        = order_rd_q;
    stop_d      = stop_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    out_valid_d = out_valid_q && out_stall_i;
    wv_d        = wv_q;
    ws_d        = ws_q;
    wp_d        = wp_q;
    hit_d       = hit_q;
    st_d        = st_q;
    order_we    = 1'b0;
    order_waddr = jdx_q[IDX_W-1:0];
    order_wdata = order_rd_q;
    prio_we     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d   = command_i;
          slot_d  = slot_i;
          prio_d  = priority_req_i;
          cap_d   = can_interrupt_i;
          minp_d  = min_priority_i;
          state_d = ST_APPLY;
        end
      end

      ST_APPLY: begin
        status_d    = STATUS_IGNORED;
        idx_d       = '0;
        jdx_d       = '0;
        stop_d      = 1'b0;
        best_d      = '0;
        best_slot_d = '0;
        state_d     = ST_SCAN;
        if (cmd_e'(cmd_q) == CMD_QUERY) begin
          status_d = STATUS_APPLIED;
        end else if (in_range) begin
          unique case (cmd_e'(cmd_q))
            CMD_REGISTER: begin
              if (!reg_q[slot_idx] && (count_q < CNT_W'(NUM_SLOTS)) &&
                  !(cap_q && (32'(prio_q) > MAX_PRIORITY))) begin
                status_d         = STATUS_APPLIED;
                prio_we          = 1'b1;
                can_d[slot_idx]  = cap_q;
                if (!cap_q) begin
                  pend_d[slot_idx] = 1'b0;
                end
                reg_d[slot_idx]  = 1'b1;
                order_we         = 1'b1;
                order_waddr      = count_q[IDX_W-1:0];
                order_wdata      = slot_idx;
                count_d          = count_q + 1'b1;
              end
            end
            CMD_DEREGISTER: begin
              if (reg_q[slot_idx]) begin
                status_d        = STATUS_APPLIED;
                reg_d[slot_idx] = 1'b0;
                state_d         = ST_COMPACT;
              end
            end
            CMD_RAISE: begin
              if (can_q[slot_idx]) begin
                status_d         = STATUS_APPLIED;
                pend_d[slot_idx] = 1'b1;
              end
            end
            CMD_CLEAR: begin
              if (can_q[slot_idx]) begin
                status_d         = STATUS_APPLIED;
                pend_d[slot_idx] = 1'b0;
              end
            end
            default: begin
              status_d = STATUS_IGNORED;
            end
          endcase
        end
      end

      ST_COMPACT: begin
        // Stream the order list through the read port and write back every
        // entry except the departing slot, one place lower per removal.
        if (idx_q < count_q) begin
          idx_d = idx_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v1_q && (order_rd_q != slot_idx)) begin
          order_we = 1'b1;
          jdx_d    = jdx_q + 1'b1;
        end
        if ((idx_q >= count_q) && !v1_q) begin
          count_d = jdx_q;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if ((idx_q < count_q) && !stop_q) begin
          idx_d = idx_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v1_q) begin
          v2_d   = 1'b1;
          elig_d = rd_in_range && reg_q[order_rd_q] && pend_q[order_rd_q];
        end
        if (v2_q && !stop_q && cmp_res.take) begin
          best_d.vld  = 1'b1;
          best_d.prio = prio_rd_q;
          best_slot_d = s2_q;
          if (cmp_res.at_max) begin
            stop_d = 1'b1;
          end
        end
        if (stop_q || ((idx_q >= count_q) && !v1_q && !v2_q)) begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          wv_d        = best_q.vld;
          ws_d        = best_q.vld ? SLOT_W'(best_slot_q) : '0;
          wp_d        = best_q.vld ? best_q.prio : '0;
          hit_d       = best_q.vld && (MINP_W'(best_q.prio) >= minp_q);
          st_d        = status_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      slot_q      <= '0;
      prio_q      <= '0;
      cap_q       <= 1'b0;
      minp_q      <= '0;
      status_q    <= STATUS_APPLIED;
      can_q       <= '0;
      pend_q      <= '0;
      reg_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      jdx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      elig_q      <= 1'b0;
      s2_q        <= '0;
      stop_q      <= 1'b0;
      best_q      <= '0;
      best_slot_q <= '0;
      out_valid_q <= 1'b0;
      wv_q        <= 1'b0;
      ws_q        <= '0;
      wp_q        <= '0;
      hit_q       <= 1'b0;
      st_q        <= STATUS_APPLIED;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      slot_q      <= slot_d;
      prio_q      <= prio_d;
      cap_q       <= cap_d;
      minp_q      <= minp_d;
      status_q    <= status_d;
      can_q       <= can_d;
      pend_q      <= pend_d;
      reg_q       <= reg_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      jdx_q       <= jdx_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      elig_q      <= elig_d;
      s2_q        <= s2_d;
      stop_q      <= stop_d;
      best_q      <= best_d;
      best_slot_q <= best_slot_d;
      out_valid_q <= out_valid_d;
      wv_q        <= wv_d;
      ws_q        <= ws_d;
      wp_q        <= wp_d;
      hit_q       <= hit_d;
      st_q        <= st_d;
    end
  end

  // Order list: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rd_q <= order_mem[idx_q[IDX_W-1:0]];
  end

  // Slot priorities, read at the slot that the order list just delivered.
  always_ff @(posedge clk_i) begin
    if (prio_we) begin
      prio_mem[slot_idx] <= prio_q;
    end
    prio_rd_q <= prio_mem[order_rd_q];
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign winner_valid_o    = wv_q;
  assign winner_slot_o     = ws_q;
  assign winner_priority_o = wp_q;
  assign query_hit_o       = hit_q;
  assign status_o          = st_q;

endmodule

`default_nettype wire
